### src/irt_pkg.sv
// Package for the interval reservation table.
// Holds parameter defaults, the result status codes and the per-cell control group.
// No dependencies.
package irt_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned TimeBitsDef = 30;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Strobes broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic capture;  // latch the overlap test for a newly accepted item
    logic insert;   // write the pending request into the first free cell
  } cell_ctrl_t;

endpackage

### src/irt_req_if.sv
// Request channel of the interval reservation table: valid/ready plus interval bounds.
// Depends on nothing.
interface irt_req_if #(
  parameter int unsigned TIME_BITS = 30
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] begin_time;
  logic [TIME_BITS-1:0] finish_time;

  modport source (output valid, output begin_time, output finish_time, input ready);
  modport sink   (input valid, input begin_time, input finish_time, output ready);
endinterface

### src/irt_rsp_if.sv
// Result channel of the interval reservation table: valid/ready plus outcome.
// Depends on irt_pkg for the status type.
interface irt_rsp_if
  import irt_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    accepted;
  status_e status;

  modport source (output valid, output accepted, output status, input ready);
  modport sink   (input valid, input accepted, input status, output ready);
endinterface

### src/irt_cell.sv
// One reservation cell: stores one interval, tests it against a request,
// and takes an insert when it is the first free cell of the row.
// Depends on irt_pkg.
module irt_cell
  import irt_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [TIME_BITS-1:0] cmp_begin_i,
  input  logic [TIME_BITS-1:0] cmp_finish_i,
  input  logic [TIME_BITS-1:0] wr_begin_i,
  input  logic [TIME_BITS-1:0] wr_finish_i,
  input  logic                 prev_valid_i,
  output logic                 valid_o,
  output logic                 hit_o
);

  logic [TIME_BITS-1:0] start_q, end_q;
  logic                 valid_q, hit_q;
  logic                 hit_d, take;

  // Conflict when begin < end and start < finish.
  assign hit_d = valid_q && (cmp_begin_i < end_q) && (start_q < cmp_finish_i);
  // Valid cells form a prefix, so the first free cell follows a valid neighbor.
  assign take  = ctrl_i.insert && !valid_q && prev_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (take) valid_q <= 1'b1;
      if (ctrl_i.capture) hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      start_q <= wr_begin_i;
      end_q   <= wr_finish_i;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

### src/interval_reservation_table.sv
// Interval reservation table: a row of cells holding half-open intervals.
// Request and cell hits are registered, then the result in the output register.
// No new item is taken while a decision is pending or the result is held, as
//   the next compare through the cell row must see the inserted interval.
// Reset: asynchronous, clears all cell valid bits and control; no clearing pass.
// Depends on irt_pkg, irt_req_if, irt_rsp_if and irt_cell.
module interval_reservation_table
  import irt_pkg::*;
#(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  irt_req_if.sink   req_i,
  irt_rsp_if.source rsp_o
);

  // Request held for the decision cycle.
  logic [TIME_BITS-1:0] beg_q, fin_q;
  logic                 pend_q;

  // Output register.
  logic    out_vld_q;
  logic    acc_q;
  status_e status_q;

  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY:0]   vld_chain;

  logic       req_fire;
  logic       empty, overlap, full;
  status_e    status_d;
  cell_ctrl_t ctrl;

  // Take a new item only with no decision pending and the output slot
  // free by the decision edge.
  assign req_i.ready = !pend_q && (!out_vld_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  // Decision cycle: combine the registered cell hits.
  assign empty   = !(fin_q > beg_q);
  assign overlap = |cell_hit;
  assign full    = cell_vld[CAPACITY-1];

  always_comb begin
    status_d = ST_ACCEPTED;
    if (empty)        status_d = ST_EMPTY;
    else if (overlap) status_d = ST_OVERLAP;
    else if (full)    status_d = ST_FULL;
  end

  assign ctrl.capture = req_fire;
  assign ctrl.insert  = pend_q && (status_d == ST_ACCEPTED);

  // Cell row: each cell sees its left neighbor's valid bit.
  assign vld_chain[0] = 1'b1;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    irt_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_begin_i  (req_i.begin_time),
      .cmp_finish_i (req_i.finish_time),
      .wr_begin_i   (beg_q),
      .wr_finish_i  (fin_q),
      .prev_valid_i (vld_chain[gi]),
      .valid_o      (cell_vld[gi]),
      .hit_o        (cell_hit[gi])
    );
    assign vld_chain[gi+1] = cell_vld[gi];
  end

  // Control: pending flag and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q <= req_fire;
      if (pend_q) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: hold the request, load the result.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      beg_q <= req_i.begin_time;
      fin_q <= req_i.finish_time;
    end
    if (pend_q) begin
      acc_q    <= (status_d == ST_ACCEPTED);
      status_q <= status_d;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.accepted = acc_q;
  assign rsp_o.status   = status_q;

  // Valid cells always form a prefix of the row.
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("cell valid bits not a prefix");

  // The output slot is free whenever a decision is pending.
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_vld_q)
    else $error("decision pending while output still held");

  // An insert fills exactly one cell.
  a_insert_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> $countones(cell_vld) == $past($countones(cell_vld)) + 1)
    else $error("insert did not fill exactly one cell");

  // Without an insert the row does not change.
  a_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.insert |=> $stable(cell_vld))
    else $error("cell valid bits changed without insert");

  // Accepted flag agrees with the status code.
  a_acc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (acc_q == (status_q == ST_ACCEPTED)))
    else $error("accepted flag disagrees with status");

endmodule
